// ----- design/opl_pkg.sv -----
// Shared constants and types for the online palindromic length block.
package opl_pkg;

    localparam int MAX_LEN = 1024;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int SYM_W   = 8;
    localparam int LEN_W   = 11;
    localparam int POS_W   = 10;
    localparam int ACC_W   = LEN_W + 1;

    localparam logic [LEN_W-1:0] BEST_MAX = {LEN_W{1'b1}};
    localparam logic [ACC_W-1:0] ACC_MAX  = {1'b0, BEST_MAX} + ACC_W'(1);
    localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_LEN);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic             upd;
        logic             clr;
        logic             wr;
        logic [SYM_W-1:0] sym;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] wr_addr;
        logic [LEN_W-1:0] best;
    } cell_ctrl_t;

    // Handed from a cell to the cell below it.
    typedef struct packed {
        logic flag;
        logic hit;
    } link_t;

endpackage

// ----- design/opl_cell.sv -----
// One start position: stored symbol, palindromic-suffix flag, prefix best and a min stage.
module opl_cell import opl_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] idx,
    input  cell_ctrl_t       ctrl,
    input  link_t            up_link,
    output link_t            link,
    input  logic [ACC_W-1:0] acc_in,
    output logic [ACC_W-1:0] acc_out
);

    logic [SYM_W-1:0] sym_reg;
    logic             flag_reg;
    logic             flag_next;
    logic [LEN_W-1:0] best_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0] cand;
    logic             hit;
    logic             below;
    logic             sym_eq;

    assign hit    = (CNT_W'(idx) == ctrl.count);
    assign below  = (CNT_W'(idx) < ctrl.count);
    assign sym_eq = (sym_reg == ctrl.sym);

    assign link.flag = flag_reg;
    assign link.hit  = hit;

    // The new symbol's own cell counts as a palindromic suffix of length zero for the cell below it.
    always_comb begin
        flag_next = hit | (below & (up_link.flag | up_link.hit) & sym_eq);
    end

    assign cand     = flag_reg ? ({1'b0, best_reg} + ACC_W'(1)) : ACC_MAX;
    assign acc_next = (cand < acc_in) ? cand : acc_in;
    assign acc_out  = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= 1'b0;
            best_reg <= '0;
        end else begin
            if (ctrl.clr) begin
                flag_reg <= 1'b0;
            end else if (ctrl.upd) begin
                flag_reg <= flag_next;
            end
            if (ctrl.wr && (CNT_W'(idx) == ctrl.wr_addr)) begin
                best_reg <= ctrl.best;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.upd && hit) begin
            sym_reg <= ctrl.sym;
        end
        // Restart the min wave on every update.
        if (ctrl.upd) begin
            acc_reg <= ACC_MAX;
        end else begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ----- design/opl_ctrl.sv -----
// Sequencer: input capture, scan timing, string length, overflow and output register.
module opl_ctrl import opl_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [SYM_W-1:0] s_symbol,
    input  logic             s_end_of_string,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [LEN_W-1:0] m_pal_length,
    output logic [POS_W-1:0] m_position,
    output logic             m_last,
    output logic             m_overflow,
    input  logic [ACC_W-1:0] acc_min,
    output cell_ctrl_t       ctrl
);

    state_t           state_reg, state_next;
    logic [SYM_W-1:0] sym_reg;
    logic             eos_reg;
    logic [CNT_W-1:0] count_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] scan_reg;
    logic             m_valid_reg;
    logic [LEN_W-1:0] m_pal_length_reg;
    logic [POS_W-1:0] m_position_reg;
    logic             m_last_reg;
    logic             m_overflow_reg;

    logic             out_free;
    logic             fin_go;
    logic             full;
    logic [LEN_W-1:0] best;
    logic [POS_W-1:0] pos_sat;

    assign out_free = !m_valid_reg || m_ready;
    assign full     = (count_reg == CNT_FULL);
    assign best     = (acc_min > ACC_W'(BEST_MAX)) ? BEST_MAX : acc_min[LEN_W-1:0];
    assign pos_sat  = (count_reg > CNT_W'(POS_MAX)) ? POS_MAX : count_reg[POS_W-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = full ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_reg == count_reg) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        fin_go       = (state_reg == ST_FINISH) && out_free;
        ctrl.upd     = (state_reg == ST_UPDATE) && !full;
        ctrl.clr     = fin_go && eos_reg;
        ctrl.wr      = fin_go && !ovf_reg;
        ctrl.sym     = sym_reg;
        ctrl.count   = count_reg;
        ctrl.wr_addr = count_reg + CNT_W'(1);
        ctrl.best    = best;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= fin_go | (m_valid_reg & !m_ready);
            if ((state_reg == ST_UPDATE) && full) begin
                ovf_reg <= 1'b1;
            end
            if (fin_go) begin
                if (eos_reg) begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end else if (!ovf_reg) begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sym_reg <= s_symbol;
            eos_reg <= s_end_of_string;
        end
        // Count the shift edges of the min wave until cell 0 holds the full min.
        if (state_reg == ST_UPDATE) begin
            scan_reg <= '0;
        end else if (state_reg == ST_SCAN) begin
            scan_reg <= scan_reg + CNT_W'(1);
        end
        if (fin_go) begin
            m_pal_length_reg <= ovf_reg ? '0 : best;
            m_position_reg   <= pos_sat;
            m_last_reg       <= eos_reg;
            m_overflow_reg   <= ovf_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pal_length = m_pal_length_reg;
    assign m_position   = m_position_reg;
    assign m_last       = m_last_reg;
    assign m_overflow   = m_overflow_reg;

endmodule

// ----- design/online_palindromic_length.sv -----
// Top level: controller and the row of position cells.
//
// Takes one byte per word on the s_ channel (s_symbol, s_end_of_string) and returns one
// word per symbol on the m_ channel: the fewest palindromes that make up the prefix
// ending at that symbol, the symbol's position in the string (saturating at 1023),
// a copy of the end marker, and an overflow flag.
// Every start position has a cell; all cells update their suffix flags together,
// then a min wave moves one cell per cycle from the top of the row down to cell 0.
// A result is loaded into the output register once the wave reaches cell 0, and the next
// word is accepted the cycle after the result is loaded; no new symbol is taken while
// one is in work. A symbol past MAX_LEN skips the min wave and answers with overflow set.
// A result waits in the output register while m_ready is low; the next symbol is
// still accepted and worked on, and holds only when its own result is ready.
// A word with s_end_of_string set clears the string state once its result is loaded.
// Reset (aresetn low, synchronous) empties the string and drops any pending result.
module online_palindromic_length import opl_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [SYM_W-1:0] s_symbol,
    input  logic             s_end_of_string,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [LEN_W-1:0] m_pal_length,
    output logic [POS_W-1:0] m_position,
    output logic             m_last,
    output logic             m_overflow
);

    cell_ctrl_t       ctrl;
    link_t            links [MAX_LEN+1];
    logic [ACC_W-1:0] accs  [MAX_LEN+1];

    assign links[MAX_LEN] = '0;
    assign accs[MAX_LEN]  = ACC_MAX;

    opl_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_symbol        (s_symbol),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pal_length    (m_pal_length),
        .m_position      (m_position),
        .m_last          (m_last),
        .m_overflow      (m_overflow),
        .acc_min         (accs[0]),
        .ctrl            (ctrl)
    );

    for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
        opl_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .idx     (IDX_W'(j)),
            .ctrl    (ctrl),
            .up_link (links[j+1]),
            .link    (links[j]),
            .acc_in  (accs[j+1]),
            .acc_out (accs[j])
        );
    end

    a_ovf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> m_pal_length == '0)
        else $error("overflow result carries a nonzero length");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_overflow |->
            (m_pal_length != '0) && (m_pal_length <= LEN_W'(m_position) + LEN_W'(1)))
        else $error("palindromic length out of range for its position");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("new word accepted while a symbol is in work");

endmodule
